// File: sv/itoar_pkg.sv
// Shared types, constants and the digit-to-character function of the radix converter.
package itoar_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned RADIX_W   = 6;
  localparam int unsigned DIGIT_W   = 5;
  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_BITS  = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 8'h41;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_NONE   = 8'h00;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 5'd10;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned OUT_DEPTH   = 2;
  localparam int unsigned OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  // classification of one accepted word, handed from front to back
  typedef struct packed {
    logic               err;
    logic               sgn;
    logic [RADIX_W-1:0] radix;
  } itoar_cls_t;

  localparam int unsigned CLS_W = $bits(itoar_cls_t);

  // one result word
  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last_char;
    logic              radix_error;
  } itoar_res_t;

  localparam int unsigned RES_W = $bits(itoar_res_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT,
    ST_ERR
  } itoar_state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_A + {3'b000, d} - {3'b000, DEC_DIGITS};
    end
    return c;
  endfunction

endpackage

// File: sv/integer_to_ascii_radix_core.sv
// Flow: a value waits in the front queue, then the back end divides out each digit
//   in turn, and for a negative decimal value it adds a minus sign.
// Throughput: one value at a time in the back end; its characters are then read out
//   most significant first, as long as the result queue has room.
// Reset (async, active low) clears the queues and the sequencer; radix returns to 10.
// The digit store has no reset: every entry read was written by the same value.
module integer_to_ascii_radix_core #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_DIGITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // radix write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [itoar_pkg::RADIX_W-1:0] cfg_radix_i,
  // input word side
  input  logic                          push,
  output logic                          full,
  input  logic signed [VALUE_WIDTH-1:0] signed_value_i,
  // result word side
  output logic                          empty,
  input  logic                          pop,
  output logic [itoar_pkg::CHAR_W-1:0]  char_out_o,
  output logic                          last_char_o,
  output logic                          radix_error_o
);

  localparam int unsigned QW = itoar_pkg::CLS_W + VALUE_WIDTH;

  logic                            q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]                   q_wdata, q_rdata;
  logic                            out_push, out_pop;
  logic [itoar_pkg::OUT_CNT_W-1:0] out_count;
  itoar_pkg::itoar_res_t           out_wdata, out_rdata;

  // Front: holds the radix, takes a word, works out sign, magnitude and
  // whether the radix is legal, and queues that classification.
  itoar_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_radix_i   (cfg_radix_i),
    .push_i        (push),
    .signed_value_i(signed_value_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_word_o      (q_wdata)
  );

  // Short queue so the front keeps accepting while the divider runs.
  itoar_fifo #(
    .WIDTH(QW),
    .DEPTH(itoar_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty),
    .count_o()
  );

  assign full = q_full;

  // Back: divides the magnitude down one digit at a time into the store,
  // least significant first, then reads it out in reverse.
  itoar_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_word_i   (q_rdata),
    .q_pop_o    (q_pop),
    .out_count_i(out_count),
    .out_pop_i  (out_pop),
    .out_push_o (out_push),
    .out_word_o (out_wdata)
  );

  // Result queue decouples the readout from a stalled consumer.
  assign out_pop = pop && !empty;

  itoar_fifo #(
    .WIDTH(itoar_pkg::RES_W),
    .DEPTH(itoar_pkg::OUT_DEPTH)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_wdata),
    .full_o (),
    .pop_i  (pop),
    .data_o (out_rdata),
    .empty_o(empty),
    .count_o(out_count)
  );

  assign char_out_o    = out_rdata.char_out;
  assign last_char_o   = out_rdata.last_char;
  assign radix_error_o = out_rdata.radix_error;

endmodule

// File: sv/itoar_fifo.sv
// Small register queue with show-ahead read; push while full is allowed only with a pop.
module itoar_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_fire, rd_fire;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign rd_fire = pop_i && !empty_o;
  assign wr_fire = push_i && (!full_o || rd_fire);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_fire) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_fire) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr_fire && !rd_fire) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (rd_fire && !wr_fire) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/itoar_front.sv
// Front end: radix register, input accept and classification of each value.
module itoar_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  logic [itoar_pkg::RADIX_W-1:0]                 cfg_radix_i,
  input  logic                                          push_i,
  input  logic signed [VALUE_WIDTH-1:0]                 signed_value_i,
  input  logic                                          q_full_i,
  output logic                                          q_push_o,
  output logic [itoar_pkg::CLS_W+VALUE_WIDTH-1:0]       q_word_o
);

  logic [itoar_pkg::RADIX_W-1:0] radix_q;
  logic [VALUE_WIDTH-1:0]        val_u;
  logic [VALUE_WIDTH-1:0]        mag;
  logic                          neg;
  itoar_pkg::itoar_cls_t         cls;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= itoar_pkg::RADIX_RESET;
    end else if (cfg_valid_i) begin
      radix_q <= cfg_radix_i;
    end
  end

  // most negative value wraps to 2^(W-1), which is its magnitude as unsigned
  assign val_u = signed_value_i;
  assign neg   = val_u[VALUE_WIDTH-1];
  assign mag   = neg ? (~val_u + VALUE_WIDTH'(1)) : val_u;

  always_comb begin
    cls.err   = (radix_q < itoar_pkg::RADIX_MIN) || (radix_q > itoar_pkg::RADIX_MAX);
    cls.sgn   = neg && (radix_q == itoar_pkg::RADIX_DEC);
    cls.radix = radix_q;
  end

  assign q_push_o = push_i && !q_full_i;
  assign q_word_o = {cls, mag};

endmodule

// File: sv/itoar_back.sv
// Back end: iterative divider, digit store and most-significant-first readout.
module itoar_back #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_DIGITS  = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    q_empty_i,
  input  logic [itoar_pkg::CLS_W+VALUE_WIDTH-1:0] q_word_i,
  output logic                                    q_pop_o,
  input  logic [itoar_pkg::OUT_CNT_W-1:0]         out_count_i,
  input  logic                                    out_pop_i,
  output logic                                    out_push_o,
  output itoar_pkg::itoar_res_t                   out_word_o
);

  localparam int unsigned DB    = itoar_pkg::DIV_BITS;
  localparam int unsigned STEPS = (VALUE_WIDTH + DB - 1) / DB;
  localparam int unsigned PW    = STEPS * DB;
  localparam int unsigned SW    = $clog2(STEPS + 1);
  localparam int unsigned NW    = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IW    = $clog2(MAX_DIGITS);
  localparam int unsigned OW    = itoar_pkg::OUT_CNT_W + 1;
  localparam int unsigned RW    = itoar_pkg::RADIX_W;
  localparam int unsigned CW    = itoar_pkg::CHAR_W;

  itoar_pkg::itoar_state_e state_q, state_d;

  logic [PW-1:0]      dvd_q, dvd_d, dvd_next;
  logic [RW-1:0]      rem_q, rem_d, rem_next;
  logic [SW-1:0]      step_q, step_d;
  logic [NW-1:0]      n_q, n_d, n_inc, n_dec;
  logic [IW-1:0]      idx_q, idx_d;
  logic [RW-1:0]      radix_q, radix_d;
  logic               sgn_q, sgn_d;
  logic               rd_vld_q, rd_last_q;
  logic [CW-1:0]      rd_data_q;
  logic [CW-1:0]      store_q [MAX_DIGITS];

  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [CW-1:0]      wr_data;
  logic               rd_issue, err_push;
  logic [OW-1:0]      occ, lim;
  logic               space;
  logic [DB-1:0]      chunk, qbits;
  logic [RW-1:0]      r;
  logic [PW+DB-1:0]   shifted;
  itoar_pkg::itoar_cls_t  cls;
  logic [VALUE_WIDTH-1:0] mag;

  assign cls = itoar_pkg::itoar_cls_t'(q_word_i[itoar_pkg::CLS_W+VALUE_WIDTH-1:VALUE_WIDTH]);
  assign mag = q_word_i[VALUE_WIDTH-1:0];

  // one radix-2 restoring step per quotient bit; remainder stays below 32
  always_comb begin
    chunk = dvd_q[PW-1 -: DB];
    r     = rem_q;
    qbits = '0;
    for (int i = DB - 1; i >= 0; i--) begin
      r = {r[RW-2:0], chunk[i]};
      if (r >= radix_q) begin
        r        = r - radix_q;
        qbits[i] = 1'b1;
      end
    end
    rem_next = r;
    shifted  = {dvd_q, qbits};
    dvd_next = shifted[PW-1:0];
  end

  // readout credit: words held plus the read in flight, less a pop this cycle
  assign occ   = {1'b0, out_count_i} + OW'(rd_vld_q);
  assign lim   = OW'(itoar_pkg::OUT_DEPTH) + OW'(out_pop_i);
  assign space = occ < lim;

  assign n_inc = n_q + NW'(1);
  assign n_dec = n_q - NW'(1);

  always_comb begin
    state_d  = state_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    step_d   = step_q;
    n_d      = n_q;
    idx_d    = idx_q;
    radix_d  = radix_q;
    sgn_d    = sgn_q;
    q_pop_o  = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = n_q[IW-1:0];
    wr_data  = itoar_pkg::digit_char(rem_next[itoar_pkg::DIGIT_W-1:0]);
    rd_issue = 1'b0;
    err_push = 1'b0;
    unique case (state_q)
      itoar_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          dvd_d   = PW'(mag);
          rem_d   = '0;
          step_d  = '0;
          n_d     = '0;
          radix_d = cls.radix;
          sgn_d   = cls.sgn;
          state_d = cls.err ? itoar_pkg::ST_ERR : itoar_pkg::ST_DIV;
        end
      end
      itoar_pkg::ST_DIV: begin
        dvd_d  = dvd_next;
        rem_d  = rem_next;
        step_d = step_q + SW'(1);
        if (step_q == SW'(STEPS - 1)) begin
          rem_d  = '0;
          step_d = '0;
          idx_d  = n_dec[IW-1:0];
          // digits past the store size are dropped, keeping the low ones
          if (n_q < NW'(MAX_DIGITS)) begin
            wr_en = 1'b1;
            n_d   = n_inc;
            idx_d = n_q[IW-1:0];
          end
          if (dvd_next == '0) begin
            if (sgn_d && (n_d < NW'(MAX_DIGITS))) begin
              state_d = itoar_pkg::ST_SIGN;
            end else begin
              state_d = itoar_pkg::ST_EMIT;
            end
          end
        end
      end
      itoar_pkg::ST_SIGN: begin
        wr_en   = 1'b1;
        wr_data = itoar_pkg::CHAR_MINUS;
        n_d     = n_inc;
        idx_d   = n_q[IW-1:0];
        state_d = itoar_pkg::ST_EMIT;
      end
      itoar_pkg::ST_EMIT: begin
        if (space) begin
          rd_issue = 1'b1;
          if (idx_q == '0) begin
            state_d = itoar_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q - IW'(1);
          end
        end
      end
      itoar_pkg::ST_ERR: begin
        if (space && !rd_vld_q) begin
          err_push = 1'b1;
          state_d  = itoar_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = itoar_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= itoar_pkg::ST_IDLE;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    step_q    <= step_d;
    n_q       <= n_d;
    idx_q     <= idx_d;
    radix_q   <= radix_d;
    sgn_q     <= sgn_d;
    rd_last_q <= (idx_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      rd_data_q <= store_q[idx_q];
    end
  end

  assign out_push_o = rd_vld_q || err_push;

  always_comb begin
    if (rd_vld_q) begin
      out_word_o.char_out    = rd_data_q;
      out_word_o.last_char   = rd_last_q;
      out_word_o.radix_error = 1'b0;
    end else begin
      out_word_o.char_out    = itoar_pkg::CHAR_NONE;
      out_word_o.last_char   = 1'b1;
      out_word_o.radix_error = 1'b1;
    end
  end

endmodule

// File: tb/itoa_text_checker.sv
// Checker for the radix converter: tracks the radix, predicts the text of each value, compares.
module itoa_text_checker
  import itoar_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_DIGITS  = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [RADIX_W-1:0]     cfg_radix_i,
  input  logic                   push_i,
  input  logic                   full_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   empty_i,
  input  logic                   pop_i,
  input  logic [CHAR_W-1:0]      char_i,
  input  logic                   last_i,
  input  logic                   error_i,
  output int                     mismatch_count_o,
  output int                     words_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [RADIX_W-1:0] radix_q;
  itoar_res_t         expected_text[$];
  itoar_res_t         seen;
  itoar_res_t         want;
  int                 mismatches;

  // Queue up the characters one value turns into at the given radix, most significant first.
  function automatic void spell_value(input logic [VALUE_WIDTH-1:0] value,
                                      input logic [RADIX_W-1:0] base);
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] digit;
    logic [CHAR_W-1:0]      ch;
    logic [CHAR_W-1:0]      text[$];
    logic                   neg;
    itoar_res_t             word;
    if (base < RADIX_MIN || base > RADIX_MAX) begin
      word.char_out    = CHAR_NONE;
      word.last_char   = 1'b1;
      word.radix_error = 1'b1;
      expected_text.push_back(word);
      return;
    end
    neg = value[VALUE_WIDTH-1];
    // unsigned negate: the most negative value lands on 2^(N-1) as it should
    mag = neg ? (~value + 1'b1) : value;
    do begin
      digit = mag % base;
      mag   = mag / base;
      if (digit < DEC_DIGITS) begin
        ch = CHAR_W'(CHAR_ZERO + digit);
      end else begin
        ch = CHAR_W'(CHAR_A + digit - DEC_DIGITS);
      end
      // keep the least significant digits if the text overflows
      if (text.size() < MAX_DIGITS) begin
        text.push_front(ch);
      end
    end while (mag != 0);
    if (neg && base == RADIX_DEC && text.size() < MAX_DIGITS) begin
      text.push_front(CHAR_MINUS);
    end
    foreach (text[k]) begin
      word.char_out    = text[k];
      word.last_char   = (k == text.size() - 1);
      word.radix_error = 1'b0;
      expected_text.push_back(word);
    end
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $time, what);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q = RADIX_RESET;
      expected_text.delete();
      mismatches = 0;
    end else begin
      if (pop_i && !empty_i) begin
        seen.char_out    = char_i;
        seen.last_char   = last_i;
        seen.radix_error = error_i;
        if (expected_text.size() == 0) begin
          note_mismatch($sformatf("unexpected word: char %h last %0b err %0b",
                                  char_i, last_i, error_i));
        end else begin
          want = expected_text.pop_front();
          if (seen !== want) begin
            note_mismatch($sformatf(
              "mismatch: expected char %h last %0b err %0b, got char %h last %0b err %0b",
              want.char_out, want.last_char, want.radix_error,
              seen.char_out, seen.last_char, seen.radix_error));
          end
        end
      end
      if (push_i && !full_i) begin
        spell_value(value_i, radix_q);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        radix_q = cfg_radix_i;
      end
    end
    mismatch_count_o <= mismatches;
    words_pending_o  <= expected_text.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the radix converter testbench: clock, reset, stimulus, idling and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import itoar_pkg::*;

  // quiet cycles allowed with no word moving on any channel
  localparam int QUIET_LIMIT = 4000;
  // drain time after the last expected word, well past one radix-2 conversion
  localparam int TAIL_CYCLES = 300;
  localparam int PHASE_WORDS = 107;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_radix;
  logic               push;
  logic               full;
  logic signed [31:0] signed_value;
  logic               empty;
  logic               pop;
  logic [CHAR_W-1:0]  char_out;
  logic               last_char;
  logic               radix_error;

  int mismatch_count;
  int words_pending;
  int quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  integer_to_ascii_radix_core #(
    .VALUE_WIDTH(32),
    .MAX_DIGITS (32)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_radix_i   (cfg_radix),
    .push          (push),
    .full          (full),
    .signed_value_i(signed_value),
    .empty         (empty),
    .pop           (pop),
    .char_out_o    (char_out),
    .last_char_o   (last_char),
    .radix_error_o (radix_error)
  );

  itoa_text_checker #(
    .VALUE_WIDTH(32),
    .MAX_DIGITS (32)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_radix_i     (cfg_radix),
    .push_i          (push),
    .full_i          (full),
    .value_i         (signed_value),
    .empty_i         (empty),
    .pop_i           (pop),
    .char_i          (char_out),
    .last_i          (last_char),
    .error_i         (radix_error),
    .mismatch_count_o(mismatch_count),
    .words_pending_o (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: a fresh pop decision every falling edge. A pop while empty is simply ignored.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Watchdog: any word moving on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one value; returns on the falling edge after it was taken. Push stays high so a
  // back-to-back value goes out with no bubble.
  task automatic send_word(input logic [31:0] value);
    logic taken;
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    signed_value <= value;
    do begin
      @(posedge clk);
      taken = !full;
      @(negedge clk);
    end while (!taken);
  endtask

  // Hold off the sender until every predicted word has come out.
  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) begin
      @(negedge clk);
    end
  endtask

  // Radix writes only happen with the converter idle.
  task automatic set_radix(input logic [RADIX_W-1:0] radix);
    logic taken;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_radix <= radix;
    do begin
      @(posedge clk);
      taken = cfg_ready;
      @(negedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly valid radices, decimal often (the only one with a sign), a few bad ones.
  function automatic logic [RADIX_W-1:0] pick_radix();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 6) begin
      return RADIX_W'($urandom_range(1, 0));
    end else if (roll < 12) begin
      return RADIX_W'($urandom_range(63, 33));
    end else if (roll < 38) begin
      return RADIX_DEC;
    end else if (roll < 44) begin
      return RADIX_MAX;
    end
    return RADIX_W'($urandom_range(32, 2));
  endfunction

  // Value mix: full-range random, small magnitudes of both signs, varied lengths, extremes.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(40, 0);
      6:          v = -32'($urandom_range(40, 1));
      7, 8: begin
        v = $urandom >> $urandom_range(31, 0);
        if ($urandom_range(1, 0) == 1) begin
          v = -v;
        end
      end
      default: begin
        case ($urandom_range(3, 0))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'hFFFF_FFFF;
          default: v = 32'h8000_0001;
        endcase
      end
    endcase
    return v;
  endfunction

  // One idling phase: radix changes every couple dozen values, and now and then the sender
  // waits for the whole backlog to drain before going on.
  task automatic run_phase(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (i % 24 == 0) begin
        set_radix(pick_radix());
      end else if ($urandom_range(39, 0) == 0) begin
        wait_drained();
      end
      send_word(pick_value());
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_radix      = '0;
    push           = 1'b0;
    signed_value   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset radix is decimal, so signs show up right away.
    send_word(32'd0);
    send_word(32'hFFFF_FFFF);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);       // most negative: magnitude 2^31, no overflow
    send_word(32'd1234567890);
    // binary: the most negative value is the longest text, 32 characters
    set_radix(RADIX_MIN);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'd6);
    // base 32 reaches the top digit 'V'; negatives print the magnitude only
    set_radix(RADIX_MAX);
    send_word(32'hFFFF_FFFF);
    send_word(32'h7FFF_FFFF);
    send_word(32'd31);
    set_radix(6'd16);
    send_word(32'hDEAD_BEEF);
    send_word(32'h0000_ABCD);
    set_radix(6'd3);
    send_word(32'h8000_0001);
    // bad radices on both sides of the valid range: one error word each
    set_radix(6'd0);
    send_word(32'd5);
    set_radix(6'd1);
    send_word(32'd5);
    set_radix(6'd33);
    send_word(32'd5);
    set_radix(6'd63);
    send_word(-32'sd7);
    set_radix(RADIX_DEC);
    send_word(-32'sd9);
    send_word(32'd10);

    // Random: full speed, slow sender, slow receiver, both moderately slow.
    run_phase(0, 0);
    run_phase(87, 0);
    run_phase(0, 87);
    run_phase(38, 38);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_drained();
    // any stray word in this window shows up in the checker as unexpected
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("TB_OK");
    end else begin
      if (words_pending != 0) begin
        $display("%0d expected words never came out", words_pending);
      end
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
